// ===== hw/rtl/lfr_pkg.sv =====
// Shared widths, codes and defaults for the linear fade ramp.
package lfr_pkg;

  localparam int LEVEL_W  = 16;
  localparam int MS_W     = 16;
  localparam int PERIOD_W = 20;
  localparam int DUTY_W   = 10;
  localparam int ACC_W    = 32;
  localparam int STEP_W   = 33;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(20000);
  localparam int CURVE_ENTRIES_DEF = 1024;
  localparam int MS_TO_US = 1000;
  localparam int MIN_DIFF = 7;

  typedef enum logic {
    KIND_FADE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

endpackage

// ===== hw/rtl/lfr_if.sv =====
// Valid/ready channels for fade commands and ticks (in) and duty words (out).
interface lfr_in_if;
  import lfr_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [LEVEL_W-1:0]  from_level;
  logic                start_from_current;
  logic [LEVEL_W-1:0]  target_level;
  logic [MS_W-1:0]     fade_ms;

  modport source(output valid, kind, from_level, start_from_current, target_level, fade_ms,
                 input ready);
  modport sink(input valid, kind, from_level, start_from_current, target_level, fade_ms,
               output ready);
endinterface

interface lfr_out_if;
  import lfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [DUTY_W-1:0]   pwm_duty;
  logic [LEVEL_W-1:0]  level;
  logic                fade_done;

  modport source(output valid, pwm_duty, level, fade_done, input ready);
  modport sink(input valid, pwm_duty, level, fade_done, output ready);
endinterface

// ===== hw/rtl/linear_fade_ramp_with_exp_curve.sv =====
// Linear fade ramp with exponential dimming curve. One word is taken at a time; in_ch.ready
// is high only when the sequencer is idle. A fade command runs the one shared restoring
// divider first to get the tick count (fade_ms*1000/tick_period_us) and then for the
// Q16.16 step, one quotient bit per cycle, and commits the fade with the last step bit.
// Commands with start and target within 6 LSB are dropped in their accept cycle. A tick
// during a fade goes through add and clamp, curve index and curve ROM read, where it waits
// for the output register; an idle tick is dropped at once. The curve ROM holds CURVE_ENTRIES
// duty values built at elaboration. cfg_wdata is written to tick_period_us when cfg_we is high.
module linear_fade_ramp_with_exp_curve #(
  parameter int CURVE_ENTRIES = lfr_pkg::CURVE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lfr_pkg::PERIOD_W-1:0]  cfg_wdata,
  lfr_in_if.sink                        in_ch,
  lfr_out_if.source                     out_ch
);
  import lfr_pkg::*;

  localparam int IDX_W  = $clog2(CURVE_ENTRIES);
  localparam int ENT_W  = $clog2(CURVE_ENTRIES + 1);
  localparam int PROD_W = LEVEL_W + ENT_W;
  localparam int DIV_W  = 32;
  localparam int DSR_W  = 26;
  localparam int CNT_W  = $clog2(DIV_W);

  localparam logic [63:0] Q28_ONE    = 64'd1 << 28;
  localparam logic [63:0] CURVE_LAST = 64'(CURVE_ENTRIES - 1);

  // Q28 Taylor sum of e^u through u^8, then raised to the 16th power
  function automatic logic [63:0] curve_exp(logic [63:0] u);
    logic [63:0] term;
    logic [63:0] sum;
    term = Q28_ONE;
    sum  = Q28_ONE;
    term = ((term * u) >> 28) / 1;  sum = sum + term;
    term = ((term * u) >> 28) / 2;  sum = sum + term;
    term = ((term * u) >> 28) / 3;  sum = sum + term;
    term = ((term * u) >> 28) / 4;  sum = sum + term;
    term = ((term * u) >> 28) / 5;  sum = sum + term;
    term = ((term * u) >> 28) / 6;  sum = sum + term;
    term = ((term * u) >> 28) / 7;  sum = sum + term;
    term = ((term * u) >> 28) / 8;  sum = sum + term;
    for (int s = 0; s < 4; s++) begin
      sum = (sum * sum) >> 28;
    end
    return sum;
  endfunction

  localparam logic [63:0] CURVE_DEN = curve_exp(64'd1 << 26) - Q28_ONE;

  function automatic logic [DUTY_W-1:0] curve_duty(int unsigned i);
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] duty;
    u = (64'(i) << 26) / CURVE_LAST;
    v = curve_exp(u);
    if (v < Q28_ONE) begin
      v = Q28_ONE;
    end
    duty = (64'd1023 * (v - Q28_ONE) + CURVE_DEN / 2) / CURVE_DEN;
    if (duty > 64'd1023) begin
      duty = 64'd1023;
    end
    return duty[DUTY_W-1:0];
  endfunction

  typedef logic [DUTY_W-1:0] curve_rom_t [CURVE_ENTRIES];

  function automatic curve_rom_t build_curve();
    curve_rom_t r;
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      r[i] = curve_duty(i);
    end
    return r;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_STEPS,
    S_DIV_SLOPE,
    S_INDEX,
    S_READ
  } state_t;

  state_t                 state_r;
  logic [PERIOD_W-1:0]    tick_period_r;
  logic [ACC_W-1:0]       acc_r;
  logic signed [STEP_W-1:0] step_r;
  logic [LEVEL_W-1:0]     target_r;
  logic                   active_r;

  logic [LEVEL_W-1:0]     new_start_r;
  logic [LEVEL_W-1:0]     new_target_r;
  logic [LEVEL_W-1:0]     diff_mag_r;
  logic                   diff_neg_r;

  logic [DIV_W-1:0]       dvd_r;
  logic [DSR_W-1:0]       rem_r;
  logic [DSR_W-1:0]       dsr_r;
  logic [CNT_W-1:0]       cnt_r;

  logic                   done_r;
  logic [IDX_W-1:0]       idx_r;

  logic                   out_valid_r;
  logic [DUTY_W-1:0]      out_pwm_r;
  logic [LEVEL_W-1:0]     out_level_r;
  logic                   out_done_r;

  // command decode
  logic [LEVEL_W-1:0]     cmd_start;
  logic signed [LEVEL_W:0] cmd_diff;
  logic                   cmd_small;
  logic [LEVEL_W:0]       cmd_mag;
  logic [DSR_W-1:0]       cmd_us;
  logic [PERIOD_W-1:0]    period;

  // shared divider step
  logic [DSR_W:0]         trial;
  logic                   fits;
  logic [DSR_W-1:0]       rem_step;
  logic [DIV_W-1:0]       dvd_step;
  logic [DSR_W-1:0]       steps;
  logic [DIV_W-1:0]       slope_mag;

  // tick datapath
  logic signed [ACC_W+1:0] tick_sum;
  logic signed [ACC_W+1:0] tick_goal;
  logic                   tick_reached;
  logic signed [ACC_W+1:0] tick_next;
  logic [PROD_W-1:0]      idx_prod;

  logic                   in_fire;
  logic                   out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pwm_duty  = out_pwm_r;
  assign out_ch.level     = out_level_r;
  assign out_ch.fade_done = out_done_r;

  always_comb begin
    cmd_start = in_ch.start_from_current ? acc_r[ACC_W-1 -: LEVEL_W] : in_ch.from_level;
    cmd_diff  = $signed({1'b0, in_ch.target_level}) - $signed({1'b0, cmd_start});
    cmd_small = (cmd_diff > -(LEVEL_W+1)'(MIN_DIFF)) && (cmd_diff < (LEVEL_W+1)'(MIN_DIFF));
    cmd_mag   = cmd_diff[LEVEL_W] ? (LEVEL_W+1)'(-cmd_diff) : (LEVEL_W+1)'(cmd_diff);
    cmd_us    = DSR_W'(in_ch.fade_ms) * DSR_W'(MS_TO_US);
    period    = (tick_period_r == '0) ? PERIOD_W'(1) : tick_period_r;
  end

  always_comb begin
    trial     = {rem_r, dvd_r[DIV_W-1]};
    fits      = trial >= {1'b0, dsr_r};
    rem_step  = fits ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
    dvd_step  = {dvd_r[DIV_W-2:0], fits};
    steps     = (dvd_step[DSR_W-1:0] == '0) ? DSR_W'(1) : dvd_step[DSR_W-1:0];
    slope_mag = (dvd_step == '0) ? DIV_W'(1) : dvd_step;
  end

  always_comb begin
    tick_sum     = $signed({2'b00, acc_r}) + (ACC_W+2)'(step_r);
    tick_goal    = $signed({2'b00, target_r, {(ACC_W-LEVEL_W){1'b0}}});
    tick_reached = step_r[STEP_W-1] ? (tick_sum <= tick_goal) : (tick_sum >= tick_goal);
    tick_next    = tick_reached ? tick_goal : tick_sum;
    if (tick_next < 0) begin
      tick_next = '0;
    end
    if (tick_next > $signed({2'b00, 16'hFFFF, 16'h0000})) begin
      tick_next = $signed({2'b00, 16'hFFFF, 16'h0000});
    end
    idx_prod = PROD_W'(acc_r[ACC_W-1 -: LEVEL_W]) * PROD_W'(CURVE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tick_period_r <= TICK_PERIOD_RST;
      acc_r         <= '0;
      step_r        <= '0;
      target_r      <= '0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        tick_period_r <= cfg_wdata;
      end
      if (state_r == S_READ && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.kind == KIND_FADE) begin
              if (!cmd_small) begin
                new_start_r  <= cmd_start;
                new_target_r <= in_ch.target_level;
                diff_mag_r   <= cmd_mag[LEVEL_W-1:0];
                diff_neg_r   <= cmd_diff[LEVEL_W];
                dvd_r        <= DIV_W'(cmd_us);
                dsr_r        <= DSR_W'(period);
                rem_r        <= '0;
                cnt_r        <= '0;
                state_r      <= S_DIV_STEPS;
              end
            end else if (active_r) begin
              acc_r    <= tick_next[ACC_W-1:0];
              done_r   <= tick_reached;
              active_r <= !tick_reached;
              state_r  <= S_INDEX;
            end
          end
        end
        S_DIV_STEPS: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_W - 1)) begin
            dvd_r   <= {diff_mag_r, {(DIV_W-LEVEL_W){1'b0}}};
            rem_r   <= '0;
            dsr_r   <= steps;
            state_r <= S_DIV_SLOPE;
          end else begin
            dvd_r <= dvd_step;
            rem_r <= rem_step;
          end
        end
        S_DIV_SLOPE: begin
          dvd_r <= dvd_step;
          rem_r <= rem_step;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_W - 1)) begin
            step_r   <= diff_neg_r ? -$signed({1'b0, slope_mag}) : $signed({1'b0, slope_mag});
            acc_r    <= {new_start_r, {(ACC_W-LEVEL_W){1'b0}}};
            target_r <= new_target_r;
            active_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_INDEX: begin
          idx_r   <= idx_prod[LEVEL_W +: IDX_W];
          state_r <= S_READ;
        end
        S_READ: begin
          if (out_free) begin
            out_pwm_r   <= CURVE_ROM[idx_r];
            out_level_r <= acc_r[ACC_W-1 -: LEVEL_W];
            out_done_r  <= done_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_active_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (step_r != '0))
    else $error("active fade with zero step");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_STEPS || state_r == S_DIV_SLOPE) |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");

  a_slope_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_SLOPE && $past(state_r) == S_DIV_STEPS) |-> (cnt_r == '0 && rem_r == '0))
    else $error("slope division did not start from zero");

  a_done_ends_fade: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INDEX && done_r) |-> !active_r)
    else $error("fade still active after reaching target");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r[ACC_W-LEVEL_W-1:0] == '0 || acc_r < {16'hFFFF, 16'h0000})
    else $error("level above full scale");

endmodule
